// ----- rtl/core/nnps_pkg.sv -----
`default_nettype none

package nnps_pkg;

   // Field widths of the channels and the configuration port.
   localparam int PIX_W      = 8;
   localparam int CFG_DIM_W  = 13;
   localparam int STEP_W     = 29;
   localparam int COL_W      = 12;
   localparam int ROW_W      = 12;
   localparam int REP_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 29;

   // Defaults for the top-level parameters.
   localparam int FRAC_BITS_DEF  = 16;
   localparam int MAX_DIM_DEF    = 4096;
   localparam int MAX_REPEAT_DEF = 16;

   // No more than this many copies are made in either direction.
   localparam int COPY_LIMIT = 16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic row_step;
      logic col_step;
      logic advance;
   } nnps_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic row_start;
      logic row_go;
      logic col_go;
      logic col_emit;
      logic out_free;
   } nnps_sts_type;

endpackage

`default_nettype wire

// ----- rtl/core/nnps_intf.sv -----
`default_nettype none

interface nnps_req_if;
   logic                        valid;
   logic                        ready;
   logic [nnps_pkg::PIX_W-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface nnps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [nnps_pkg::PIX_W-1:0]  pixel_out;
   logic [nnps_pkg::COL_W-1:0]  dst_col;
   logic [nnps_pkg::ROW_W-1:0]  dst_row;
   logic [nnps_pkg::REP_W-1:0]  row_copies;
   logic                        run_last;

   modport source (output valid, output pixel_out, output dst_col, output dst_row,
                   output row_copies, output run_last, input ready);
   modport sink   (input valid, input pixel_out, input dst_col, input dst_row,
                   input row_copies, input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nnps_csr.sv -----
`default_nettype none

module nnps_csr #(
   parameter int MAX_DIM = nnps_pkg::MAX_DIM_DEF,
   localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [nnps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [nnps_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic      [DIM_W-1:0]                src_w,
   output logic      [DIM_W-1:0]                src_h,
   output logic      [DIM_W-1:0]                dst_w,
   output logic      [DIM_W-1:0]                dst_h,
   output logic      [nnps_pkg::STEP_W-1:0]     step_x,
   output logic      [nnps_pkg::STEP_W-1:0]     step_y
);
   import nnps_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y     = 3'd5;

   localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 13'd640;
   localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 13'd480;
   localparam logic [STEP_W-1:0]    STEP_RST   = 29'd65536;

   logic [CFG_DIM_W-1:0] src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [STEP_W-1:0]    step_x_ff, step_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= WIDTH_RST;
         src_height_ff <= HEIGHT_RST;
         dst_width_ff  <= WIDTH_RST;
         dst_height_ff <= HEIGHT_RST;
         step_x_ff     <= STEP_RST;
         step_y_ff     <= STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[CFG_DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[CFG_DIM_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata[CFG_DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata[CFG_DIM_W-1:0];
            CSR_STEP_X:     step_x_ff     <= csr_wdata[STEP_W-1:0];
            CSR_STEP_Y:     step_y_ff     <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Sizes above MAX_DIM act as MAX_DIM; a source size of zero acts as one.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                  input logic lowest_one);
      logic [DIM_W-1:0] r;
      if (lowest_one && v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   assign src_w  = clamp_dim(src_width_ff, 1'b1);
   assign src_h  = clamp_dim(src_height_ff, 1'b1);
   assign dst_w  = clamp_dim(dst_width_ff, 1'b0);
   assign dst_h  = clamp_dim(dst_height_ff, 1'b0);
   assign step_x = step_x_ff;
   assign step_y = step_y_ff;

endmodule

`default_nettype wire

// ----- rtl/core/nnps_ctrl.sv -----
`default_nettype none

module nnps_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire nnps_pkg::nnps_sts_type sts,
   output nnps_pkg::nnps_cmd_type      cmd
);
   import nnps_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROWS = 2'd1;
   localparam logic [1:0] ST_COLS = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.row_start ? ST_ROWS : ST_COLS;
            end
         end
         ST_ROWS: begin
            if (sts.row_go) begin
               cmd.row_step = 1'b1;
            end else begin
               state_in = ST_COLS;
            end
         end
         ST_COLS: begin
            if (sts.col_go) begin
               // A column that yields an item waits for room in the output register.
               cmd.col_step = !sts.col_emit || sts.out_free;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/nnps_dp.sv -----
`default_nettype none

module nnps_dp #(
   parameter int FRAC_BITS  = nnps_pkg::FRAC_BITS_DEF,
   parameter int MAX_DIM    = nnps_pkg::MAX_DIM_DEF,
   parameter int MAX_REPEAT = nnps_pkg::MAX_REPEAT_DEF,
   localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire nnps_pkg::nnps_cmd_type       cmd,
   output nnps_pkg::nnps_sts_type            sts,
   input  wire logic [nnps_pkg::PIX_W-1:0]   pixel_in,
   input  wire logic [DIM_W-1:0]             src_w,
   input  wire logic [DIM_W-1:0]             src_h,
   input  wire logic [DIM_W-1:0]             dst_w,
   input  wire logic [DIM_W-1:0]             dst_h,
   input  wire logic [nnps_pkg::STEP_W-1:0]  step_x,
   input  wire logic [nnps_pkg::STEP_W-1:0]  step_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [nnps_pkg::PIX_W-1:0]   rsp_pixel_out,
   output logic      [nnps_pkg::COL_W-1:0]   rsp_dst_col,
   output logic      [nnps_pkg::ROW_W-1:0]   rsp_dst_row,
   output logic      [nnps_pkg::REP_W-1:0]   rsp_row_copies,
   output logic                              rsp_run_last
);
   import nnps_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int ACC_W = ((CNT_W + FRAC_BITS) > STEP_W ? (CNT_W + FRAC_BITS) : STEP_W) + 1;
   localparam int POS_W = ACC_W - FRAC_BITS;
   localparam int CAP   = (MAX_REPEAT < COPY_LIMIT) ? MAX_REPEAT : COPY_LIMIT;

   logic [CNT_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [DIM_W-1:0] dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [ACC_W-1:0] col_acc_ff, col_acc_in, row_acc_ff, row_acc_in;
   logic [ROW_W-1:0] row_first_ff, row_first_in;
   logic [REP_W-1:0] row_rep_ff, row_rep_in;
   logic [REP_W-1:0] n_ff, n_in;
   logic [PIX_W-1:0] pix_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [POS_W-1:0] col_pos, col_pos_nx, row_pos, src_col_pos, src_row_pos;
   logic [ACC_W-1:0] col_acc_nx;
   logic [DIM_W:0]   dst_col_inc;
   logic [CNT_W:0]   src_col_inc, src_row_inc;
   logic             row_hit, col_last, emit, col_wrap, frame_wrap;

   assign src_col_pos = POS_W'(src_col_ff);
   assign src_row_pos = POS_W'(src_row_ff);
   assign col_pos     = col_acc_ff[ACC_W-1:FRAC_BITS];
   assign row_pos     = row_acc_ff[ACC_W-1:FRAC_BITS];
   assign col_acc_nx  = col_acc_ff + ACC_W'(step_x);
   assign col_pos_nx  = col_acc_nx[ACC_W-1:FRAC_BITS];
   assign dst_col_inc = {1'b0, dst_col_ff} + (DIM_W+1)'(1);
   assign row_hit     = (row_pos == src_row_pos);

   assign sts.row_start = (src_col_ff == '0);
   assign sts.row_go    = (dst_row_ff < dst_h) && (row_pos <= src_row_pos);
   assign sts.col_go    = (row_rep_ff != '0) && (dst_col_ff < dst_w) && (col_pos <= src_col_pos);
   assign sts.col_emit  = (col_pos == src_col_pos) && (n_ff < REP_W'(CAP));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // Columns that map to this pixel form one contiguous run, so the item is the
   // last one when the following column falls outside it or the cap is reached.
   assign col_last = (n_ff == REP_W'(CAP - 1)) ||
                     !((dst_col_inc < {1'b0, dst_w}) && (col_pos_nx == src_col_pos));

   assign emit        = cmd.col_step && sts.col_emit;
   assign src_col_inc = {1'b0, src_col_ff} + (CNT_W+1)'(1);
   assign src_row_inc = {1'b0, src_row_ff} + (CNT_W+1)'(1);
   assign col_wrap    = src_col_inc >= (CNT_W+1)'(src_w);
   assign frame_wrap  = col_wrap && (src_row_inc >= (CNT_W+1)'(src_h));

   always_comb begin
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      dst_col_in   = dst_col_ff;
      dst_row_in   = dst_row_ff;
      col_acc_in   = col_acc_ff;
      row_acc_in   = row_acc_ff;
      row_first_in = row_first_ff;
      row_rep_in   = row_rep_ff;
      n_in         = n_ff;

      if (cmd.accept) begin
         n_in = '0;
         if (sts.row_start) begin
            col_acc_in   = '0;
            dst_col_in   = '0;
            row_rep_in   = '0;
            row_first_in = ROW_W'(dst_row_ff);
         end
      end

      if (cmd.row_step) begin
         if (row_hit) begin
            if (row_rep_ff == '0) begin
               row_first_in = ROW_W'(dst_row_ff);
            end
            if (row_rep_ff < REP_W'(CAP)) begin
               row_rep_in = row_rep_ff + REP_W'(1);
            end
         end
         row_acc_in = row_acc_ff + ACC_W'(step_y);
         dst_row_in = dst_row_ff + DIM_W'(1);
      end

      if (cmd.col_step) begin
         col_acc_in = col_acc_nx;
         dst_col_in = dst_col_inc[DIM_W-1:0];
         if (sts.col_emit) begin
            n_in = n_ff + REP_W'(1);
         end
      end

      if (cmd.advance) begin
         if (col_wrap) begin
            src_col_in = '0;
            if (frame_wrap) begin
               src_row_in = '0;
               row_acc_in = '0;
               dst_row_in = '0;
            end else begin
               src_row_in = src_row_inc[CNT_W-1:0];
            end
         end else begin
            src_col_in = src_col_inc[CNT_W-1:0];
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         dst_col_ff   <= '0;
         dst_row_ff   <= '0;
         col_acc_ff   <= '0;
         row_acc_ff   <= '0;
         row_first_ff <= '0;
         row_rep_ff   <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         dst_col_ff   <= dst_col_in;
         dst_row_ff   <= dst_row_in;
         col_acc_ff   <= col_acc_in;
         row_acc_ff   <= row_acc_in;
         row_first_ff <= row_first_in;
         row_rep_ff   <= row_rep_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= pixel_in;
      end
      if (emit) begin
         rsp_pixel_out  <= pix_ff;
         rsp_dst_col    <= COL_W'(dst_col_ff);
         rsp_dst_row    <= row_first_ff;
         rsp_row_copies <= row_rep_ff;
         rsp_run_last   <= col_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_item_count_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= REP_W'(CAP))
      else $error("more items produced for one pixel than the cap allows");

   a_row_copies_cap: assert property (@(posedge clock) disable iff (reset)
      row_rep_ff <= REP_W'(CAP))
      else $error("row copy count above the cap");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("item written over a result that was not taken");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.advance && frame_wrap) |=> (dst_row_ff == '0 && row_acc_ff == '0 && src_row_ff == '0))
      else $error("row state not cleared at frame end");

   a_one_step_kind: assert property (@(posedge clock) disable iff (reset)
      !(cmd.row_step && cmd.col_step) && !(cmd.accept && cmd.advance))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ----- rtl/core/nearest_neighbor_pixel_scaler.sv -----
// Nearest-neighbor scaler for one 8-bit image plane. Source pixels enter in raster order on
// the req_chan channel; for each one the block sends, on rsp_chan, one item per destination
// column that maps to it (at most min(MAX_REPEAT,16)), each carrying the first destination
// row and the number of destination rows that repeat this source row, so the writer copies
// the row; a dropped pixel yields no item. Registers on the csr_ port, by index: 0 source
// width, 1 source height, 2 destination width, 3 destination height, 4 step_x, 5 step_y,
// steps in fixed point with FRAC_BITS fraction bits; write them only between items. One
// shared stepping unit walks the accumulators one destination position per cycle while
// the output register has room for any item that the column step yields: a pixel is
// first accepted, then at the first pixel of each source row the destination rows are
// examined and that row scan is ended, then the destination columns are examined, and a
// closing step advances the source position. Items wait in an output register, so a
// stalled sink holds the scan only when the next column item is due.
`default_nettype none

module nearest_neighbor_pixel_scaler #(
   parameter int FRAC_BITS  = nnps_pkg::FRAC_BITS_DEF,
   parameter int MAX_DIM    = nnps_pkg::MAX_DIM_DEF,
   parameter int MAX_REPEAT = nnps_pkg::MAX_REPEAT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   nnps_req_if.sink                             req_chan,
   nnps_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_wr_en,
   input  wire logic [nnps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [nnps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nnps_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [DIM_W-1:0]  src_w, src_h, dst_w, dst_h;
   logic [STEP_W-1:0] step_x, step_y;
   nnps_cmd_type      cmd;
   nnps_sts_type      sts;

   nnps_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .src_w     (src_w),
      .src_h     (src_h),
      .dst_w     (dst_w),
      .dst_h     (dst_h),
      .step_x    (step_x),
      .step_y    (step_y)
   );

   nnps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nnps_dp #(
      .FRAC_BITS  (FRAC_BITS),
      .MAX_DIM    (MAX_DIM),
      .MAX_REPEAT (MAX_REPEAT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .pixel_in       (req_chan.pixel_in),
      .src_w          (src_w),
      .src_h          (src_h),
      .dst_w          (dst_w),
      .dst_h          (dst_h),
      .step_x         (step_x),
      .step_y         (step_y),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_pixel_out  (rsp_chan.pixel_out),
      .rsp_dst_col    (rsp_chan.dst_col),
      .rsp_dst_row    (rsp_chan.dst_row),
      .rsp_row_copies (rsp_chan.row_copies),
      .rsp_run_last   (rsp_chan.run_last)
   );

endmodule

`default_nettype wire

// ----- bench/nearest_neighbor_pixel_scaler_tb.sv -----
module nearest_neighbor_pixel_scaler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nnps_pkg::*;

   localparam int FRAC_BITS   = FRAC_BITS_DEF;
   localparam int MAX_DIM     = MAX_DIM_DEF;
   localparam int COPY_CAP    = (MAX_REPEAT_DEF < COPY_LIMIT) ? MAX_REPEAT_DEF : COPY_LIMIT;
   localparam int UNITY_STEP  = 1 << FRAC_BITS;
   localparam int TARGET_ITEMS = 360;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int unsigned MAX_STEP = (1 << STEP_W) - 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_SRC_HEIGHT = 3'd1,
      REG_DST_WIDTH  = 3'd2,
      REG_DST_HEIGHT = 3'd3,
      REG_STEP_X     = 3'd4,
      REG_STEP_Y     = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [REP_W-1:0] copies;
      logic             last;
   } dest_pixel_type;

   logic clock;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   nnps_req_if req_chan ();
   nnps_rsp_if rsp_chan ();

   nearest_neighbor_pixel_scaler dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the register file.
   int unsigned     cfg_src_w = 640;
   int unsigned     cfg_src_h = 480;
   int unsigned     cfg_dst_w = 640;
   int unsigned     cfg_dst_h = 480;
   longint unsigned cfg_step_x = UNITY_STEP;
   longint unsigned cfg_step_y = UNITY_STEP;

   // Scan position of the scaler.
   int unsigned     in_col = 0;
   int unsigned     in_row = 0;
   int unsigned     out_col = 0;
   int unsigned     out_row = 0;
   longint unsigned col_acc = 0;
   longint unsigned row_acc = 0;
   int unsigned     run_row = 0;
   int unsigned     run_copies = 0;

   dest_pixel_type dest_pixels_due[$];

   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_cycles = 0;
   bit          gaps_on = 1'b0;
   bit          stalls_on = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned fit_size(input int unsigned v, input int unsigned lowest);
      if (v < lowest) return lowest;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // Works out the destination pixels that one source pixel produces and advances the scan.
   function automatic void scale_pixel(input logic [PIX_W-1:0] pix);
      int unsigned sw;
      int unsigned sh;
      int unsigned dw;
      int unsigned dh;
      dest_pixel_type p;
      dest_pixel_type run[$];
      sw = fit_size(cfg_src_w, 1);
      sh = fit_size(cfg_src_h, 1);
      dw = fit_size(cfg_dst_w, 0);
      dh = fit_size(cfg_dst_h, 0);

      if (in_col == 0) begin
         col_acc    = 0;
         out_col    = 0;
         run_copies = 0;
         run_row    = out_row;
         while (out_row < dh && (row_acc >> FRAC_BITS) <= in_row) begin
            if ((row_acc >> FRAC_BITS) == in_row) begin
               if (run_copies == 0) run_row = out_row;
               if (run_copies < COPY_CAP) run_copies++;
            end
            row_acc += cfg_step_y;
            out_row++;
         end
      end

      if (run_copies > 0) begin
         while (out_col < dw && (col_acc >> FRAC_BITS) <= in_col) begin
            if ((col_acc >> FRAC_BITS) == in_col && run.size() < COPY_CAP) begin
               p.pixel  = pix;
               p.col    = out_col[COL_W-1:0];
               p.row    = run_row[ROW_W-1:0];
               p.copies = run_copies[REP_W-1:0];
               p.last   = 1'b0;
               run.push_back(p);
            end
            col_acc += cfg_step_x;
            out_col++;
         end
         if (run.size() > 0) run[run.size()-1].last = 1'b1;
         foreach (run[i]) dest_pixels_due.push_back(run[i]);
      end

      in_col++;
      if (in_col >= sw) begin
         in_col = 0;
         in_row++;
         if (in_row >= sh) begin
            in_row  = 0;
            row_acc = 0;
            out_row = 0;
         end
      end
   endfunction

   // A pixel with no output may still be scanning rows and columns after the last item.
   function automatic int unsigned settle_cycles();
      return fit_size(cfg_dst_w, 0) + fit_size(cfg_dst_h, 0) + 40;
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.pixel_in <= pix;
      do @(posedge clock); while (!req_chan.ready);
      scale_pixel(pix);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (dest_pixels_due.size() != 0) @(posedge clock);
      repeat (settle_cycles()) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_SRC_WIDTH:  cfg_src_w = 32'(val[CFG_DIM_W-1:0]);
         REG_SRC_HEIGHT: cfg_src_h = 32'(val[CFG_DIM_W-1:0]);
         REG_DST_WIDTH:  cfg_dst_w = 32'(val[CFG_DIM_W-1:0]);
         REG_DST_HEIGHT: cfg_dst_h = 32'(val[CFG_DIM_W-1:0]);
         REG_STEP_X:     cfg_step_x = 64'(val[STEP_W-1:0]);
         REG_STEP_Y:     cfg_step_y = 64'(val[STEP_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned sw, input int unsigned sh,
                            input int unsigned dw, input int unsigned dh,
                            input int unsigned sx, input int unsigned sy);
      wait_idle();
      write_reg(REG_SRC_WIDTH, CSR_DATA_W'(sw));
      write_reg(REG_SRC_HEIGHT, CSR_DATA_W'(sh));
      write_reg(REG_DST_WIDTH, CSR_DATA_W'(dw));
      write_reg(REG_DST_HEIGHT, CSR_DATA_W'(dh));
      write_reg(REG_STEP_X, CSR_DATA_W'(sx));
      write_reg(REG_STEP_Y, CSR_DATA_W'(sy));
      csr_wr_en <= 1'b0;
   endtask

   // A one-pixel frame brings the source and row counters back to the frame origin.
   task automatic start_frame();
      configure(1, 1, cfg_dst_w, cfg_dst_h, 32'(cfg_step_x), 32'(cfg_step_y));
      send_pixel(PIX_W'($urandom));
   endtask

   task automatic test_reset_defaults();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h55);
      send_pixel(8'hAA);
      start_frame();
   endtask

   task automatic test_upscale();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      configure(2, 2, 40, 40, UNITY_STEP / 16, UNITY_STEP / 16);
      repeat (4) send_pixel(PIX_W'($urandom));
      // Thirty-two columns and rows match each pixel, only sixteen are kept.
      configure(2, 1, 64, 64, UNITY_STEP / 32, UNITY_STEP / 32);
      repeat (2) send_pixel(PIX_W'($urandom));
   endtask

   task automatic test_downscale();
      configure(2, 2, 1, 1, 2 * UNITY_STEP, 2 * UNITY_STEP);
      repeat (4) send_pixel(PIX_W'($urandom));
   endtask

   task automatic test_size_limits();
      // Zero source sizes act as one; a zero destination width gives nothing.
      configure(0, 0, 0, 5, UNITY_STEP, UNITY_STEP);
      repeat (2) send_pixel(PIX_W'($urandom));
      // Oversized destination with a zero step: everything maps to the origin.
      configure(0, 0, 8191, 1, 0, 0);
      send_pixel(PIX_W'($urandom));
      configure(1, 1, 1, 8191, 0, 0);
      send_pixel(PIX_W'($urandom));
      configure(2, 2, 2, 2, MAX_STEP, MAX_STEP);
      repeat (4) send_pixel(PIX_W'($urandom));
   endtask

   task automatic test_backpressure();
      configure(2, 1, 32, 1, UNITY_STEP / 16, UNITY_STEP);
      gaps_on     = 1'b0;
      stalls_on   = 1'b1;
      hold_cycles = 400;
      repeat (12) send_pixel(PIX_W'($urandom));
      wait_idle();
   endtask

   task automatic test_random_frames();
      int unsigned mode;
      int unsigned sw;
      int unsigned sh;
      int unsigned dw;
      int unsigned dh;
      int unsigned sx;
      int unsigned sy;
      int unsigned count;
      bit          broken;
      while (items_sent < TARGET_ITEMS) begin
         mode      = $urandom_range(0, 11);
         gaps_on   = $urandom_range(0, 3) != 0;
         stalls_on = $urandom_range(0, 3) != 0;
         broken    = 1'b0;
         if (mode <= 7) begin
            sw = $urandom_range(1, 6);
            sh = $urandom_range(1, 5);
            dw = $urandom_range(1, 12);
            dh = $urandom_range(1, 10);
            sx = (sw << FRAC_BITS) / dw;
            sy = (sh << FRAC_BITS) / dh;
            count = sw * sh * $urandom_range(1, 2);
            if ($urandom_range(0, 7) == 0) begin
               count  = $urandom_range(1, count);
               broken = 1'b1;
            end
         end else if (mode == 8) begin
            sw = $urandom_range(1, 3);
            sh = $urandom_range(1, 3);
            dw = $urandom_range(1, 40);
            dh = $urandom_range(1, 40);
            sx = $urandom_range(0, UNITY_STEP / 16);
            sy = $urandom_range(0, UNITY_STEP / 16);
            count = sw * sh;
         end else if (mode == 9) begin
            // A rare wide destination; the column scan is long, so only one short frame.
            sw = $urandom_range(1, 2);
            sh = 1;
            dw = $urandom_range(64, MAX_DIM);
            dh = $urandom_range(1, 4);
            sx = (sw << FRAC_BITS) / dw;
            sy = UNITY_STEP / dh;
            count = sw;
         end else begin
            sw = $urandom;
            sh = $urandom;
            dw = $urandom;
            dh = $urandom;
            sx = $urandom;
            sy = $urandom;
            count  = $urandom_range(1, 6);
            broken = 1'b1;
         end
         configure(sw, sh, dw, dh, sx, sy);
         repeat (count) send_pixel(PIX_W'($urandom));
         if (broken) start_frame();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.pixel_in <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= REG_SRC_WIDTH;
      csr_wdata         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_upscale();
      test_downscale();
      test_size_limits();
      test_backpressure();
      test_random_frames();

      wait_idle();
      if (error_count == 0 && dest_pixels_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold-off when a test asks for it.
   initial begin
      int unsigned stall;
      dest_pixel_type got;
      dest_pixel_type want;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles > 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = stalls_on ? $urandom_range(0, 16) : 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);

         got.pixel  = rsp_chan.pixel_out;
         got.col    = rsp_chan.dst_col;
         got.row    = rsp_chan.dst_row;
         got.copies = rsp_chan.row_copies;
         got.last   = rsp_chan.run_last;
         if (dest_pixels_due.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected item: pix %02h col %0d row %0d copies %0d last %0b",
                        got.pixel, got.col, got.row, got.copies, got.last);
         end else begin
            want = dest_pixels_due.pop_front();
            if (got.pixel !== want.pixel || got.col !== want.col || got.row !== want.row ||
                got.copies !== want.copies || got.last !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected pix %02h col %0d row %0d copies %0d last %0b, %s",
                           want.pixel, want.col, want.row, want.copies, want.last,
                           $sformatf("got pix %02h col %0d row %0d copies %0d last %0b",
                                     got.pixel, got.col, got.row, got.copies, got.last));
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/nnps_pkg.sv
rtl/core/nnps_intf.sv
rtl/core/nnps_csr.sv
rtl/core/nnps_ctrl.sv
rtl/core/nnps_dp.sv
rtl/core/nearest_neighbor_pixel_scaler.sv
bench/nearest_neighbor_pixel_scaler_tb.sv
